// ===== rtl/core/rdmc_pkg.sv =====
package rdmc_pkg;

  localparam int MAX_SIZE    = 64;
  localparam int STACK_DEPTH = 1024;

  localparam int CW        = $clog2(MAX_SIZE);
  localparam int GS_W      = 7;
  localparam int VIS_DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int VIS_AW    = 2 * CW;
  localparam int STK_AW    = $clog2(STACK_DEPTH);
  localparam int LVL_W     = STK_AW + 1;
  localparam int EPOCH_W   = 4;
  localparam int RND_W     = 8;

  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_GRID_SIZE = REG_IDX_W'(0);
  localparam logic [GS_W-1:0]      GRID_RESET    = GS_W'(63);

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_DRAW  = 1'b1;

  typedef logic [CW-1:0]      coord_t;
  typedef logic [EPOCH_W-1:0] epoch_t;

  localparam epoch_t EPOCH_MAX = '1;

  typedef enum logic [1:0] {
    KIND_OPEN     = 2'd0,
    KIND_DISCARD  = 2'd1,
    KIND_FINISHED = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_E = 2'd1,
    DIR_W = 2'd2,
    DIR_S = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_NBR,
    S_NLAST,
    S_FIN,
    S_POP_RD,
    S_POP_CHK,
    S_VIS,
    S_OPEN_T
  } state_t;

  // bit0 north, bit1 east, bit2 west, bit3 south
  typedef struct packed {
    coord_t     x;
    coord_t     y;
    logic [3:0] mask;
  } frame_t;

  typedef struct packed {
    logic              we;
    logic [VIS_AW-1:0] waddr;
    epoch_t            wdata;
    logic [VIS_AW-1:0] raddr;
  } vis_req_t;

  typedef struct packed {
    logic              we;
    logic [STK_AW-1:0] waddr;
    frame_t            wdata;
    logic [STK_AW-1:0] raddr;
  } stk_req_t;

  // x mod 3 by reciprocal, exact for 8-bit x
  function automatic logic [1:0] mod3(input logic [RND_W-1:0] x);
    logic [15:0]      p;
    logic [RND_W-1:0] q;
    logic [RND_W-1:0] r;
    p = 16'(x) * 16'd171;
    q = RND_W'(p[15:9]);
    r = x - RND_W'(q * RND_W'(3));
    return r[1:0];
  endfunction

  function automatic dir_t pick_dir(input logic [3:0] mask, input logic [RND_W-1:0] rnd);
    logic [2:0] count;
    logic [1:0] k;
    logic [2:0] seen;
    dir_t       dir;
    count = 3'($countones(mask));
    seen  = '0;
    dir   = DIR_N;
    case (count)
      3'd1:    k = 2'd0;
      3'd2:    k = {1'b0, rnd[0]};
      3'd3:    k = mod3(rnd);
      default: k = rnd[1:0];
    endcase
    for (int b = 0; b < 4; b++) begin
      if (mask[b]) begin
        if (seen == {1'b0, k}) dir = dir_t'(2'(b));
        seen = seen + 3'd1;
      end
    end
    return dir;
  endfunction

endpackage

// ===== rtl/core/rdmc_if.sv =====
interface rdmc_item_if;
  import rdmc_pkg::*;
  logic             valid;
  logic             ready;
  logic             action;
  coord_t           start_x;
  coord_t           start_y;
  logic [RND_W-1:0] random_byte;

  modport source (output valid, action, start_x, start_y, random_byte, input ready);
  modport sink   (input valid, action, start_x, start_y, random_byte, output ready);
endinterface

interface rdmc_result_if;
  import rdmc_pkg::*;
  logic   valid;
  logic   ready;
  kind_t  kind;
  coord_t cell_x;
  coord_t cell_y;
  logic   last;

  modport source (output valid, kind, cell_x, cell_y, last, input ready);
  modport sink   (input valid, kind, cell_x, cell_y, last, output ready);
endinterface

// ===== rtl/core/random_dfs_maze_carver_core.sv =====
// Channel   Dir  Payload                                  Transfer
// item      in   action, start_x, start_y, random_byte    valid && ready
// result    out  kind, cell_x, cell_y, last               valid && ready
// apb cfg   in   grid_size at byte address 0              psel && penable && pwrite
//
// One item in flight. A start steps through accept, open, four visited-memory
// reads for the neighbour mask, frame push. A draw reads and pops empty frames,
// then discards, or opens wall and target and runs the start's reads and push;
// on an empty stack it finishes. A held-off result stalls the emitting state.
// Visited cells carry a 4-bit epoch; reset and every 15th start run a clearing
// pass over all 4096 visited-memory entries with item.ready low.
module random_dfs_maze_carver_core (
  input  logic                          clk,
  input  logic                          rst,
  rdmc_item_if.sink                     item,
  rdmc_result_if.source                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rdmc_pkg::PADDR_W-1:0]  paddr,
  input  logic [rdmc_pkg::PDATA_W-1:0]  pwdata,
  output logic [rdmc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import rdmc_pkg::*;

  logic [GS_W-1:0] grid_size;
  vis_req_t        vis_req;
  epoch_t          vis_rdata;
  stk_req_t        stk_req;
  frame_t          stk_rdata;

  rdmc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .grid_size (grid_size)
  );

  rdmc_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (VIS_DEPTH)
  ) u_vis_ram (
    .clk   (clk),
    .we    (vis_req.we),
    .waddr (vis_req.waddr),
    .wdata (vis_req.wdata),
    .raddr (vis_req.raddr),
    .rdata (vis_rdata)
  );

  rdmc_ram #(
    .WIDTH ($bits(frame_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stk_ram (
    .clk   (clk),
    .we    (stk_req.we),
    .waddr (stk_req.waddr),
    .wdata (stk_req.wdata),
    .raddr (stk_req.raddr),
    .rdata (stk_rdata)
  );

  rdmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .grid_size (grid_size),
    .item      (item),
    .result    (result),
    .vis_req   (vis_req),
    .vis_rdata (vis_rdata),
    .stk_req   (stk_req),
    .stk_rdata (stk_rdata)
  );

endmodule

// ===== rtl/core/rdmc_ram.sv =====
module rdmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/rdmc_cfg.sv =====
module rdmc_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rdmc_pkg::PADDR_W-1:0]    paddr,
  input  logic [rdmc_pkg::PDATA_W-1:0]    pwdata,
  output logic [rdmc_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  output logic [rdmc_pkg::GS_W-1:0]       grid_size
);
  import rdmc_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (idx == REG_GRID_SIZE) ? PDATA_W'(grid_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GRID_RESET;
    end else if (wr && idx == REG_GRID_SIZE) begin
      grid_size <= pwdata[GS_W-1:0];
    end
  end

endmodule

// ===== rtl/core/rdmc_ctrl.sv =====
module rdmc_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [rdmc_pkg::GS_W-1:0]  grid_size,
  rdmc_item_if.sink                  item,
  rdmc_result_if.source              result,
  output rdmc_pkg::vis_req_t         vis_req,
  input  rdmc_pkg::epoch_t           vis_rdata,
  output rdmc_pkg::stk_req_t         stk_req,
  input  rdmc_pkg::frame_t           stk_rdata
);
  import rdmc_pkg::*;

  state_t              state, state_next;
  epoch_t              epoch, epoch_next;
  logic [LVL_W-1:0]    level, level_next;
  logic [VIS_AW-1:0]   clr_cnt, clr_cnt_next;
  logic                pend_start, pend_start_next;
  coord_t              tx, tx_next, ty, ty_next, wx, wx_next, wy, wy_next;
  logic [1:0]          nbr_idx, nbr_idx_next;
  logic [3:0]          nmask, nmask_next;
  logic [RND_W-1:0]    rnd, rnd_next;

  logic                res_valid;
  kind_t               res_kind;
  coord_t              res_x, res_y;
  logic                res_last;

  logic                emit;
  kind_t               emit_kind;
  coord_t              emit_x, emit_y;
  logic                emit_last;

  logic                out_free;
  logic [GS_W-1:0]     side;
  logic [3:0]          rng;
  logic                hit;
  logic [1:0]          chk_idx;
  coord_t              nb_x, nb_y;
  logic [LVL_W-1:0]    lvl_m1, lvl_m2;
  dir_t                dir;
  coord_t              ptx, pty, pwx, pwy;

  assign out_free = !res_valid || result.ready;
  assign side     = (grid_size > GS_W'(MAX_SIZE)) ? GS_W'(MAX_SIZE) : grid_size;
  assign hit      = (vis_rdata == epoch);
  assign lvl_m1   = level - LVL_W'(1);
  assign lvl_m2   = level - LVL_W'(2);
  assign chk_idx  = (state == S_NLAST) ? 2'd3 : nbr_idx - 2'd1;

  assign rng[0] = (ty >= coord_t'(2));
  assign rng[1] = ((GS_W'(tx) + GS_W'(2)) < side);
  assign rng[2] = (tx >= coord_t'(2));
  assign rng[3] = ((GS_W'(ty) + GS_W'(2)) < side);

  always_comb begin
    nb_x = tx;
    nb_y = ty;
    case (dir_t'(nbr_idx))
      DIR_N:   nb_y = ty - coord_t'(2);
      DIR_E:   nb_x = tx + coord_t'(2);
      DIR_W:   nb_x = tx - coord_t'(2);
      default: nb_y = ty + coord_t'(2);
    endcase
  end

  assign dir = pick_dir(stk_rdata.mask, rnd);

  always_comb begin
    ptx = stk_rdata.x;
    pty = stk_rdata.y;
    pwx = stk_rdata.x;
    pwy = stk_rdata.y;
    case (dir)
      DIR_N: begin
        pty = stk_rdata.y - coord_t'(2);
        pwy = stk_rdata.y - coord_t'(1);
      end
      DIR_E: begin
        ptx = stk_rdata.x + coord_t'(2);
        pwx = stk_rdata.x + coord_t'(1);
      end
      DIR_W: begin
        ptx = stk_rdata.x - coord_t'(2);
        pwx = stk_rdata.x - coord_t'(1);
      end
      default: begin
        pty = stk_rdata.y + coord_t'(2);
        pwy = stk_rdata.y + coord_t'(1);
      end
    endcase
  end

  always_comb begin
    state_next      = state;
    epoch_next      = epoch;
    level_next      = level;
    clr_cnt_next    = clr_cnt;
    pend_start_next = pend_start;
    tx_next         = tx;
    ty_next         = ty;
    wx_next         = wx;
    wy_next         = wy;
    nbr_idx_next    = nbr_idx;
    nmask_next      = nmask;
    rnd_next        = rnd;
    emit            = 1'b0;
    emit_kind       = KIND_OPEN;
    emit_x          = '0;
    emit_y          = '0;
    emit_last       = 1'b0;
    vis_req         = '{we: 1'b0, waddr: {ty, tx}, wdata: epoch, raddr: {ty, tx}};
    stk_req         = '{we: 1'b0, waddr: lvl_m1[STK_AW-1:0], wdata: stk_rdata,
                        raddr: lvl_m1[STK_AW-1:0]};
    case (state)
      S_CLEAR: begin
        vis_req.we    = 1'b1;
        vis_req.waddr = clr_cnt;
        vis_req.wdata = '0;
        clr_cnt_next  = clr_cnt + VIS_AW'(1);
        if (&clr_cnt) begin
          epoch_next      = epoch_t'(1);
          pend_start_next = 1'b0;
          state_next      = pend_start ? S_START : S_IDLE;
        end
      end
      S_IDLE: begin
        if (item.valid) begin
          if (item.action == ACT_START) begin
            level_next = '0;
            tx_next    = item.start_x;
            ty_next    = item.start_y;
            if (epoch == EPOCH_MAX) begin
              clr_cnt_next    = '0;
              pend_start_next = 1'b1;
              state_next      = S_CLEAR;
            end else begin
              epoch_next = epoch + epoch_t'(1);
              state_next = S_START;
            end
          end else begin
            rnd_next   = item.random_byte;
            state_next = (level == '0) ? S_FIN : S_POP_RD;
          end
        end
      end
      S_START: begin
        if (GS_W'(tx) >= side || GS_W'(ty) >= side) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          vis_req.we   = 1'b1;
          emit         = 1'b1;
          emit_x       = tx;
          emit_y       = ty;
          emit_last    = 1'b1;
          nbr_idx_next = '0;
          state_next   = S_NBR;
        end
      end
      S_NBR: begin
        vis_req.raddr = {nb_y, nb_x};
        if (nbr_idx != 2'd0) nmask_next[chk_idx] = rng[chk_idx] && !hit;
        nbr_idx_next = nbr_idx + 2'd1;
        if (nbr_idx == 2'd3) state_next = S_NLAST;
      end
      S_NLAST: begin
        if (level < LVL_W'(STACK_DEPTH)) begin
          stk_req.we    = 1'b1;
          stk_req.waddr = level[STK_AW-1:0];
          stk_req.wdata = '{x: tx, y: ty, mask: {rng[3] && !hit, nmask[2:0]}};
          level_next    = level + LVL_W'(1);
        end
        state_next = S_IDLE;
      end
      S_FIN: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_kind  = KIND_FINISHED;
          emit_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_POP_RD: begin
        state_next = S_POP_CHK;
      end
      S_POP_CHK: begin
        if (stk_rdata.mask == 4'd0) begin
          level_next    = lvl_m1;
          stk_req.raddr = lvl_m2[STK_AW-1:0];
          if (level == LVL_W'(1)) state_next = S_FIN;
        end else begin
          stk_req.we         = 1'b1;
          stk_req.wdata.mask = stk_rdata.mask & ~(4'd1 << dir);
          tx_next            = ptx;
          ty_next            = pty;
          wx_next            = pwx;
          wy_next            = pwy;
          vis_req.raddr      = {pty, ptx};
          state_next         = S_VIS;
        end
      end
      S_VIS: begin
        if (out_free) begin
          emit = 1'b1;
          if (hit) begin
            emit_kind  = KIND_DISCARD;
            emit_last  = 1'b1;
            state_next = S_IDLE;
          end else begin
            vis_req.we    = 1'b1;
            vis_req.waddr = {wy, wx};
            emit_x        = wx;
            emit_y        = wy;
            state_next    = S_OPEN_T;
          end
        end
      end
      S_OPEN_T: begin
        if (out_free) begin
          vis_req.we   = 1'b1;
          emit         = 1'b1;
          emit_x       = tx;
          emit_y       = ty;
          emit_last    = 1'b1;
          nbr_idx_next = '0;
          state_next   = S_NBR;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      epoch      <= '0;
      level      <= '0;
      clr_cnt    <= '0;
      pend_start <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      epoch      <= epoch_next;
      level      <= level_next;
      clr_cnt    <= clr_cnt_next;
      pend_start <= pend_start_next;
      if (emit) res_valid <= 1'b1;
      else if (result.ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    tx      <= tx_next;
    ty      <= ty_next;
    wx      <= wx_next;
    wy      <= wy_next;
    nbr_idx <= nbr_idx_next;
    nmask   <= nmask_next;
    rnd     <= rnd_next;
    if (emit) begin
      res_kind <= emit_kind;
      res_x    <= emit_x;
      res_y    <= emit_y;
      res_last <= emit_last;
    end
  end

  assign item.ready    = (state == S_IDLE);
  assign result.valid  = res_valid;
  assign result.kind   = res_kind;
  assign result.cell_x = res_x;
  assign result.cell_y = res_y;
  assign result.last   = res_last;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_epoch_live: assert property (@(posedge clk) disable iff (rst)
    state != S_CLEAR |-> epoch != '0)
    else $error("zero epoch outside clearing pass");

  a_vis_mark: assert property (@(posedge clk) disable iff (rst)
    vis_req.we && state != S_CLEAR |-> vis_req.wdata == epoch)
    else $error("visited write with stale epoch");

  a_stk_level: assert property (@(posedge clk) disable iff (rst)
    stk_req.we |=> level != '0)
    else $error("frame written with empty stack");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result overwritten before transfer");

endmodule
